// ----- rtl/kdbr_pkg.sv -----
`default_nettype none

package kdbr_pkg;

    localparam int DUTY_W      = 10;
    localparam int STEP_W      = 10;
    localparam int MAX_DUTY    = 1000;
    localparam int FRAC_BITS_D = 8;
    localparam int ALPHA_W     = 16;

    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(50);

    localparam logic [ALPHA_W-1:0] ALPHA_BASE_LONG  = 16'd26214;
    localparam logic [ALPHA_W-1:0] ALPHA_BASE_SHORT = 16'd17039;
    localparam logic [ALPHA_W-1:0] ALPHA_SLOPE_LONG  = 16'd8389;
    localparam logic [ALPHA_W-1:0] ALPHA_SLOPE_SHORT = 16'd7046;
    localparam logic [ALPHA_W-1:0] ALPHA_CAP        = 16'd55706;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SYNC  = 2'd1;
    localparam logic [1:0] CMD_APPLY = 2'd2;
    localparam logic [1:0] CMD_OFF   = 2'd3;

    localparam logic [2:0] KEY_NONE    = 3'd0;
    localparam logic [2:0] KEY_DN_SHRT = 3'd1;
    localparam logic [2:0] KEY_UP_SHRT = 3'd2;
    localparam logic [2:0] KEY_DN_LONG = 3'd3;
    localparam logic [2:0] KEY_UP_LONG = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] key;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] target_duty;
    } t_out;

    function automatic logic key_is_long(input logic [2:0] key);
        return (key == KEY_DN_LONG) || (key == KEY_UP_LONG);
    endfunction

    function automatic logic key_is_short(input logic [2:0] key);
        return (key == KEY_DN_SHRT) || (key == KEY_UP_SHRT);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kdbr_mul.sv -----
`default_nettype none

module kdbr_mul #(
    parameter int A_W = 18,
    parameter int B_W = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [A_W-1:0]       i_a,
    input  wire logic [B_W-1:0]       i_b,
    output logic                      o_busy,
    output logic [A_W+B_W-1:0]        o_prod
);

    localparam int CNT_W = $clog2(A_W + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic [A_W+B_W-1:0]   r_acc;
    logic [B_W-1:0]       r_b;
    logic [B_W:0]         n_sum;

    always_comb begin
        n_sum = {1'b0, r_acc[A_W+B_W-1:A_W]} + (r_acc[0] ? {1'b0, r_b} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(A_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // shift one multiplier bit out per cycle, add the multiplicand on a one
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{B_W{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_cnt != '0) begin
            r_acc <= {n_sum, r_acc[A_W-1:1]};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/key_driven_brightness_ramp_core.sv -----
`default_nettype none

// Brightness ramp driven by key ticks. Each accepted item gives one result
// (rounded duty, clamped target). A tick whose filter step needs the alpha
// multiplies runs both multiplies on one shared shift-add unit that takes one
// bit of |diff| per cycle. A tick that snaps onto the target skips them, and a
// sync, apply or off command goes straight to the output state. The next item
// is accepted while the previous result still waits in the output register.
module key_driven_brightness_ramp_core #(
    parameter int FRAC_BITS = kdbr_pkg::FRAC_BITS_D
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire kdbr_pkg::t_in                i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output kdbr_pkg::t_out                    o_out_data,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [kdbr_pkg::STEP_W-1:0]  i_cfg_wr_data
);

    localparam int DW    = kdbr_pkg::DUTY_W;
    localparam int AW    = kdbr_pkg::ALPHA_W;
    localparam int W     = DW + FRAC_BITS;
    localparam int PW    = W + AW;
    localparam int SH_W  = PW - FRAC_BITS - 8;
    localparam int TS_W  = DW + 3;

    localparam logic [W-1:0] HALF_Q   = W'(1) << (FRAC_BITS - 1);
    localparam logic [W-1:0] MS_LONG  = W'(4) << FRAC_BITS;
    localparam logic [W-1:0] MS_SHORT = W'(5) << (FRAC_BITS - 1);
    localparam logic [W-1:0] MS_NONE  = W'(2) << FRAC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TGT  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_STEP = 3'd5;
    localparam logic [2:0] ST_DUTY = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]                  r_state;
    logic [kdbr_pkg::STEP_W-1:0] r_step;
    logic [DW-1:0]               r_target;
    logic [W-1:0]                r_filt;
    logic [DW-1:0]               r_duty;
    logic                        r_out_valid;

    logic [1:0]                  r_cmd;
    logic [2:0]                  r_key;
    logic [W-1:0]                r_absdiff;
    logic                        r_up;
    logic [W-1:0]                r_delta;
    kdbr_pkg::t_out              r_out_data;

    logic                        in_fire;
    logic                        out_load;

    logic [kdbr_pkg::STEP_W:0]   step_amt;
    logic signed [TS_W-1:0]      t_base;
    logic signed [TS_W-1:0]      t_amt;
    logic signed [TS_W-1:0]      t_sum;
    logic [DW-1:0]               n_target;

    logic [W-1:0]                tq;
    logic                        n_up;
    logic [W-1:0]                n_absdiff;
    logic                        snap;

    logic                        mul_start;
    logic                        mul_busy;
    logic [W-1:0]                mul_a;
    logic [AW-1:0]               mul_b;
    logic [PW-1:0]               mul_prod;

    logic [AW-1:0]               alpha_base;
    logic [AW-1:0]               alpha_slope;
    logic [SH_W:0]               alpha_sum;
    logic [AW-1:0]               alpha;

    logic [W-1:0]                min_step;
    logic [W-1:0]                delta_raw;
    logic [W-1:0]                delta_lo;
    logic [W-1:0]                n_delta;
    logic [W:0]                  duty_sum;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // target move
    always_comb begin
        step_amt = kdbr_pkg::key_is_long(r_key) ? {r_step, 1'b0} : {1'b0, r_step};
        t_base   = $signed({3'b000, r_target});
        t_amt    = $signed({2'b00, step_amt});
        unique case (r_key)
            kdbr_pkg::KEY_DN_SHRT, kdbr_pkg::KEY_DN_LONG: t_sum = t_base - t_amt;
            kdbr_pkg::KEY_UP_SHRT, kdbr_pkg::KEY_UP_LONG: t_sum = t_base + t_amt;
            default:                                      t_sum = t_base;
        endcase
        priority if (t_sum < 0) begin
            n_target = '0;
        end else if (t_sum > $signed(TS_W'(kdbr_pkg::MAX_DUTY))) begin
            n_target = DW'(kdbr_pkg::MAX_DUTY);
        end else begin
            n_target = t_sum[DW-1:0];
        end
    end

    // distance to target
    always_comb begin
        tq        = {r_target, {FRAC_BITS{1'b0}}};
        n_up      = (tq >= r_filt);
        n_absdiff = n_up ? (tq - r_filt) : (r_filt - tq);
        snap      = (n_absdiff <= HALF_Q);
    end

    // alpha from the first product, capped
    always_comb begin
        alpha_base  = kdbr_pkg::key_is_long(r_key) ? kdbr_pkg::ALPHA_BASE_LONG
                                                   : kdbr_pkg::ALPHA_BASE_SHORT;
        alpha_slope = kdbr_pkg::key_is_long(r_key) ? kdbr_pkg::ALPHA_SLOPE_LONG
                                                   : kdbr_pkg::ALPHA_SLOPE_SHORT;
        alpha_sum   = (SH_W+1)'(alpha_base) + {1'b0, mul_prod[FRAC_BITS+8 +: SH_W]};
        alpha       = (alpha_sum > (SH_W+1)'(kdbr_pkg::ALPHA_CAP)) ? kdbr_pkg::ALPHA_CAP
                                                                    : alpha_sum[AW-1:0];
    end

    always_comb begin
        mul_start = ((r_state == ST_DIFF) && !snap) ||
                    ((r_state == ST_MUL1) && !mul_busy);
        mul_a     = (r_state == ST_DIFF) ? n_absdiff : r_absdiff;
        mul_b     = (r_state == ST_DIFF) ? alpha_slope : alpha;
    end

    kdbr_mul #(
        .A_W (W),
        .B_W (AW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    // minimum step, then no overshoot
    always_comb begin
        priority if (kdbr_pkg::key_is_long(r_key)) begin
            min_step = MS_LONG;
        end else if (kdbr_pkg::key_is_short(r_key)) begin
            min_step = MS_SHORT;
        end else begin
            min_step = MS_NONE;
        end
        delta_raw = mul_prod[AW +: W];
        delta_lo  = (delta_raw < min_step) ? min_step : delta_raw;
        n_delta   = (delta_lo > r_absdiff) ? r_absdiff : delta_lo;
        duty_sum  = {1'b0, r_filt} + {1'b0, HALF_Q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= kdbr_pkg::STEP_RESET;
            r_target    <= '0;
            r_filt      <= '0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    unique case (r_cmd)
                        kdbr_pkg::CMD_TICK: begin
                            r_target <= n_target;
                            r_state  <= ST_DIFF;
                        end
                        kdbr_pkg::CMD_SYNC: begin
                            r_target <= r_duty;
                            r_filt   <= {r_duty, {FRAC_BITS{1'b0}}};
                            r_state  <= ST_OUT;
                        end
                        kdbr_pkg::CMD_APPLY: begin
                            r_duty  <= r_target;
                            r_filt  <= {r_target, {FRAC_BITS{1'b0}}};
                            r_state <= ST_OUT;
                        end
                        default: begin
                            r_duty  <= '0;
                            r_filt  <= '0;
                            r_state <= ST_OUT;
                        end
                    endcase
                end
                ST_DIFF: begin
                    if (snap) begin
                        r_filt  <= tq;
                        r_state <= ST_DUTY;
                    end else begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    if (!mul_busy) begin
                        r_state <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    if (!mul_busy) begin
                        r_state <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    r_filt  <= r_up ? (r_filt + r_delta) : (r_filt - r_delta);
                    r_state <= ST_DUTY;
                end
                ST_DUTY: begin
                    r_duty  <= DW'(duty_sum >> FRAC_BITS);
                    r_state <= ST_OUT;
                end
                default: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_data.command;
            r_key <= i_in_data.key;
        end
        if (r_state == ST_DIFF) begin
            r_absdiff <= n_absdiff;
            r_up      <= n_up;
        end
        if ((r_state == ST_MUL2) && !mul_busy) begin
            r_delta <= n_delta;
        end
        if (out_load) begin
            r_out_data.duty        <= r_duty;
            r_out_data.target_duty <= r_target;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target <= DW'(kdbr_pkg::MAX_DUTY))
        else $error("target above full scale");

    a_filt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filt <= {DW'(kdbr_pkg::MAX_DUTY), {FRAC_BITS{1'b0}}})
        else $error("filter above full scale");

    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> (r_delta <= r_absdiff))
        else $error("filter step overshoots target");

    a_mul_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> !mul_busy ##1 (r_state == ST_TGT))
        else $error("item accepted while multiplier busy");
`endif

endmodule

`default_nettype wire
